// File: rtl/imu_bias_calibration_assert.svh
// Assertion macros for the IMU bias calibration block.
`ifndef IMU_BIAS_CALIBRATION_ASSERT_SVH
`define IMU_BIAS_CALIBRATION_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define IBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle forces a consequence in the next.
`define IBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/imubc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubc_pkg
// Types and constants shared by the IMU bias calibration modules.
// ----------------------------------------------------------------------------
package imubc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 12;
    localparam int DIVC_W   = $clog2(SUM_W + 1);
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 33;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_N   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_N  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMU_NEG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_NEG  = 3'd5;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [31:0] mag_x;
        logic signed [31:0] mag_y;
        logic signed [31:0] mag_z;
    } t_imu_in;

    typedef struct packed {
        logic signed [31:0] out_accel_x;
        logic signed [31:0] out_accel_y;
        logic signed [31:0] out_accel_z;
        logic signed [31:0] out_gyro_x;
        logic signed [31:0] out_gyro_y;
        logic signed [31:0] out_gyro_z;
        logic signed [31:0] out_mag_x;
        logic signed [31:0] out_mag_y;
        logic signed [31:0] out_mag_z;
        logic               mag_valid;
        logic               calibrated;
        logic               sensor_missing;
    } t_imu_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_CHK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQ,
        S_SQA,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_ZB,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// File: rtl/imu_bias_calibration.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_bias_calibration
// Sums IMU samples, derives gyro/accel biases and corrects every sample.
// ----------------------------------------------------------------------------
// One request at a time. While calibration is pending a request passes through
// accept, sum update, finish check and output load. Once calibration is done,
// or both enables are clear, it passes through accept, pass and output load.
// The sample that completes calibration also goes through, before output load:
// - six means through the shared 48-step divider, each followed by a square step;
// - three squares through one multiplier;
// - a 33-step square root, with start and capture;
// - the bias update.
// Input stall is high while a request is in progress. A finished result waits
// in the output register, and a held output adds its stall cycles to the next
// request.
module imu_bias_calibration (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  imubc_pkg::t_imu_in                 i_in,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output imubc_pkg::t_imu_out                o_out,
    input  wire                                i_cfg_we,
    input  wire  [imubc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [imubc_pkg::CNT_W-1:0]        i_cfg_wdata
);
    import imubc_pkg::*;

    t_state r_state, n_state;

    logic             r_gen, r_aen;
    logic [CNT_W-1:0] r_gn, r_an;
    logic [2:0]       r_ineg, r_mneg;

    t_imu_in                 r_smp;
    logic signed [SUM_W-1:0] r_sum [6];
    logic [CNT_W-1:0]        r_count;
    logic signed [31:0]      r_gb [3];
    logic signed [31:0]      r_ab [3];
    logic signed [31:0]      r_mean [6];
    logic [2:0]              r_k;
    logic [SQ_W-1:0]         r_prod, r_sqacc;
    logic [ROOT_W-1:0]       r_g;
    logic                    r_done, r_missing;
    t_imu_out                r_out;
    logic                    r_ov;

    logic [CNT_W-1:0]        target;
    logic                    pending, all_zero, out_load;
    logic signed [31:0]      smp [6];
    logic signed [SUM_W-1:0] sum_nx [6];
    logic                    div_start, root_start;
    t_unit_stat              div_stat, root_stat;
    logic [SUM_W-1:0]        div_quot, sum_mag;
    logic [ROOT_W-1:0]       root;
    logic                    sum_neg;
    logic signed [31:0]      mean_nx;
    logic [31:0]             mean_abs;
    logic signed [ROOT_W+1:0] zb;
    t_imu_out                out_nx;

    function automatic logic signed [31:0] f_sat_neg(input logic signed [32:0] c,
                                                      input logic neg);
        logic signed [33:0] v;
        v = neg ? -{c[32], c} : {c[32], c};
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            return v[31:0];
        return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sum_add(input logic signed [SUM_W-1:0] s,
                                                          input logic signed [31:0] x);
        logic signed [SUM_W:0] e;
        e = {s[SUM_W-1], s} + (SUM_W+1)'(x);
        if (e[SUM_W] != e[SUM_W-1])
            return e[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return e[SUM_W-1:0];
    endfunction

    imubc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag + SUM_W'(r_count >> 1)),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    imubc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_val   (r_sqacc),
        .o_stat  (root_stat),
        .o_root  (root)
    );

    always_comb begin
        target   = (r_gn > r_an) ? r_gn : r_an;
        pending  = !r_done && (r_gen || r_aen);
        smp[0] = r_smp.accel_x; smp[1] = r_smp.accel_y; smp[2] = r_smp.accel_z;
        smp[3] = r_smp.gyro_x;  smp[4] = r_smp.gyro_y;  smp[5] = r_smp.gyro_z;
        all_zero = 1'b1;
        for (int i = 0; i < 6; i++) begin
            sum_nx[i] = f_sum_add(r_sum[i], smp[i]);
            if (r_sum[i] != '0)
                all_zero = 1'b0;
        end
        sum_neg = r_sum[r_k][SUM_W-1];
        sum_mag = sum_neg ? SUM_W'(-r_sum[r_k]) : SUM_W'(r_sum[r_k]);
        // mean magnitude clamps at 2^31, then sign and 32-bit saturation
        if (sum_neg)
            mean_nx = (|div_quot[SUM_W-1:31]) ? 32'sh8000_0000 : -$signed(div_quot[31:0]);
        else
            mean_nx = (|div_quot[SUM_W-1:31]) ? 32'sh7FFF_FFFF : $signed(div_quot[31:0]);
        mean_abs = r_mean[r_k][31] ? 32'(-r_mean[r_k]) : 32'(r_mean[r_k]);
        if (r_ineg[2])
            zb = (ROOT_W+2)'(r_mean[2]) + $signed({2'b00, r_g});
        else
            zb = (ROOT_W+2)'(r_mean[2]) - $signed({2'b00, r_g});

        out_nx.out_accel_x = f_sat_neg(33'(r_smp.accel_x) - 33'(r_ab[0]), r_ineg[0]);
        out_nx.out_accel_y = f_sat_neg(33'(r_smp.accel_y) - 33'(r_ab[1]), r_ineg[1]);
        out_nx.out_accel_z = f_sat_neg(33'(r_smp.accel_z) - 33'(r_ab[2]), r_ineg[2]);
        out_nx.out_gyro_x  = f_sat_neg(33'(r_smp.gyro_x) - 33'(r_gb[0]), r_ineg[0]);
        out_nx.out_gyro_y  = f_sat_neg(33'(r_smp.gyro_y) - 33'(r_gb[1]), r_ineg[1]);
        out_nx.out_gyro_z  = f_sat_neg(33'(r_smp.gyro_z) - 33'(r_gb[2]), r_ineg[2]);
        out_nx.out_mag_x   = f_sat_neg(33'(r_smp.mag_x), r_mneg[0]);
        out_nx.out_mag_y   = f_sat_neg(33'(r_smp.mag_y), r_mneg[1]);
        out_nx.out_mag_z   = f_sat_neg(33'(r_smp.mag_z), r_mneg[2]);
        out_nx.mag_valid   = (r_smp.mag_x != '0) || (r_smp.mag_y != '0) ||
                             (r_smp.mag_z != '0);
        out_nx.calibrated     = r_done;
        out_nx.sensor_missing = r_missing;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_ACC;
            S_ACC: begin
                if (pending && target != '0) n_state = S_CHK;
                else n_state = S_OUT;
            end
            S_CHK: begin
                if (r_count >= target && !all_zero) n_state = S_DIV_GO;
                else n_state = S_OUT;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_stat.done) n_state = S_SQ;
            end
            S_SQ: begin
                if (r_k < 3'd3) n_state = S_SQA;
                else if (r_k == 3'd5) n_state = S_ROOT_GO;
                else n_state = S_DIV_GO;
            end
            S_SQA:       n_state = S_DIV_GO;
            S_ROOT_GO: begin
                root_start = 1'b1;
                n_state    = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: if (root_stat.done) n_state = S_ZB;
            S_ZB:        n_state = S_OUT;
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gen     <= 1'b1;
            r_aen     <= 1'b1;
            r_gn      <= CNT_W'(200);
            r_an      <= CNT_W'(200);
            r_ineg    <= 3'd5;
            r_mneg    <= 3'd5;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_missing <= 1'b0;
            r_ov      <= 1'b0;
            r_k       <= '0;
            for (int i = 0; i < 6; i++) r_sum[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_gb[i] <= '0;
                r_ab[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GYRO_EN:  r_gen  <= i_cfg_wdata[0];
                    CFG_ACCEL_EN: r_aen  <= i_cfg_wdata[0];
                    CFG_GYRO_N:   r_gn   <= i_cfg_wdata;
                    CFG_ACCEL_N:  r_an   <= i_cfg_wdata;
                    CFG_IMU_NEG:  r_ineg <= i_cfg_wdata[2:0];
                    CFG_MAG_NEG:  r_mneg <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_smp <= i_in;
                S_ACC: begin
                    if (pending) begin
                        if (target == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            for (int i = 0; i < 6; i++) r_sum[i] <= sum_nx[i];
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_CHK: begin
                    r_k     <= '0;
                    r_sqacc <= '0;
                    if (r_count >= target && all_zero) begin
                        r_done    <= 1'b1;
                        r_missing <= 1'b1;
                    end
                end
                S_DIV_WAIT: if (div_stat.done) r_mean[r_k] <= mean_nx;
                S_SQ: begin
                    r_prod <= SQ_W'(mean_abs) * SQ_W'(mean_abs);
                    if (r_k >= 3'd3 && r_k != 3'd5) r_k <= r_k + 1'b1;
                end
                S_SQA: begin
                    r_sqacc <= r_sqacc + r_prod;
                    r_k     <= r_k + 1'b1;
                end
                S_ROOT_WAIT: if (root_stat.done) r_g <= root;
                S_ZB: begin
                    r_done <= 1'b1;
                    if (r_gen) begin
                        for (int i = 0; i < 3; i++) r_gb[i] <= r_mean[3 + i];
                    end
                    if (r_aen) begin
                        r_ab[0] <= r_mean[0];
                        r_ab[1] <= r_mean[1];
                        if (zb[ROOT_W+1:32] != '0 && zb[ROOT_W+1:32] != '1)
                            r_ab[2] <= zb[ROOT_W+1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        else
                            r_ab[2] <= f_sat_neg(zb[32:0], 1'b0);
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                r_out <= out_nx;
                r_ov  <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`include "imu_bias_calibration_assert.svh"

    `IBC_ASSERT(a_busy_stall, (r_state != S_IDLE) |-> o_in_stall, "request taken while busy")
    `IBC_ASSERT(a_missing_done, r_missing |-> r_done, "missing flag without finish")
    `IBC_ASSERT(a_div_idle, div_start |-> !div_stat.busy, "divider restarted while busy")
    `IBC_ASSERT_NEXT(a_out_load, out_load, o_out_valid, "loaded result not presented")

endmodule
`default_nettype wire

// File: rtl/imubc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubc_div
// Restoring divider, one quotient bit per cycle, for the axis means.
// ----------------------------------------------------------------------------
module imubc_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  [imubc_pkg::SUM_W-1:0]    i_dividend,
    input  wire  [imubc_pkg::CNT_W-1:0]    i_divisor,
    output imubc_pkg::t_unit_stat          o_stat,
    output logic [imubc_pkg::SUM_W-1:0]    o_quot
);
    import imubc_pkg::*;

    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_q, n_q;
    logic [CNT_W-1:0]  r_d;
    logic [DIVC_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [CNT_W:0]    trial;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_q[SUM_W-1]};
        qbit  = (trial >= {1'b0, r_d});
        n_rem = qbit ? CNT_W'(trial - {1'b0, r_d}) : trial[CNT_W-1:0];
        n_q   = {r_q[SUM_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIVC_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_q;

endmodule
`default_nettype wire

// File: rtl/imubc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubc_sqrt
// Bit-pair square root with round to nearest, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module imubc_sqrt (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire  [imubc_pkg::SQ_W-1:0]     i_val,
    output imubc_pkg::t_unit_stat          o_stat,
    output logic [imubc_pkg::ROOT_W-1:0]   o_root
);
    import imubc_pkg::*;

    logic [SQ_W-1:0]   r_res, r_rem, r_bit;
    logic [ROOT_W-1:0] r_root;
    logic              r_busy, r_done;
    logic [SQ_W-1:0]   t;

    assign t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_res  <= '0;
                r_rem  <= i_val;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    // remainder is v - res^2: round up when it passes res
                    r_root <= ROOT_W'(r_res) + ROOT_W'(r_rem > r_res);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_rem >= t) begin
                        r_rem <= r_rem - t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_root = r_root;

endmodule
`default_nettype wire

// File: tb/imubc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imubc_checker
// Watches the sample, result and register ports of the IMU bias calibration
// block, keeps its own copy of the calibration state, predicts each corrected
// sample and compares the results field by field in order.
// ----------------------------------------------------------------------------
module imubc_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  imubc_pkg::t_imu_in                 i_in,
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  imubc_pkg::t_imu_out                i_out,
    input  wire                                i_cfg_we,
    input  wire  [imubc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [imubc_pkg::CNT_W-1:0]        i_cfg_wdata,
    output int                                 o_errors,
    output int                                 o_pending
);
    import imubc_pkg::*;

    localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // register copies
    bit          gyro_en, accel_en;
    bit [11:0]   gyro_n, accel_n;
    bit [2:0]    imu_neg, mag_neg;

    // calibration state
    longint      axis_sum [6];
    bit [11:0]   n_summed;
    longint      gyro_bias [3];
    longint      accel_bias [3];
    bit          cal_done, imu_missing;

    t_imu_out    corrected_q [$];

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rounded_mean(longint s, int unsigned n);
        longint unsigned mag;
        longint unsigned q;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        q = (mag + n / 2) / n;
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        return clip32((s < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint unsigned rounded_root(longint unsigned v);
        longint unsigned res, bitv, rem;
        res = 0;
        bitv = 64'd1 << 62;
        rem = v;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v - res * res > res) res++;
        return res;
    endfunction

    function automatic void set_biases();
        bit               all_zero;
        longint           m [3];
        longint unsigned  sq, g;
        all_zero = 1;
        foreach (axis_sum[i]) if (axis_sum[i] != 0) all_zero = 0;
        cal_done = 1;
        if (n_summed == 0 || all_zero) begin
            imu_missing = 1;
            return;
        end
        if (gyro_en)
            for (int i = 0; i < 3; i++) gyro_bias[i] = rounded_mean(axis_sum[3+i], n_summed);
        if (accel_en) begin
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = rounded_mean(axis_sum[i], n_summed);
                sq = sq + longint'(m[i] * m[i]);
            end
            g = rounded_root(sq);
            accel_bias[0] = m[0];
            accel_bias[1] = m[1];
            // gravity sign follows the z-axis negate bit (imu_neg[2])
            accel_bias[2] = clip32(imu_neg[2] ? m[2] + longint'(g) : m[2] - longint'(g));
        end
    endfunction

    function automatic t_imu_out correct_sample(t_imu_in x);
        longint    s [9];
        longint    c, bias;
        bit [11:0] target;
        t_imu_out  r;
        s = '{x.accel_x, x.accel_y, x.accel_z, x.gyro_x, x.gyro_y, x.gyro_z,
              x.mag_x, x.mag_y, x.mag_z};
        if (!cal_done && (gyro_en || accel_en)) begin
            target = (gyro_n > accel_n) ? gyro_n : accel_n;
            if (target == 0) begin
                cal_done = 1;
            end else begin
                for (int i = 0; i < 6; i++) begin
                    c = axis_sum[i] + s[i];
                    axis_sum[i] = (c > SUM_MAX) ? SUM_MAX : (c < SUM_MIN) ? SUM_MIN : c;
                end
                n_summed++;
                if (n_summed >= target) set_biases();
            end
        end
        r = '0;
        for (int i = 0; i < 6; i++) begin
            bias = (i < 3) ? accel_bias[i] : gyro_bias[i-3];
            c = s[i] - bias;
            if (imu_neg[i % 3]) c = -c;
            s[i] = clip32(c);
        end
        for (int i = 6; i < 9; i++) begin
            if (s[i] != 0) r.mag_valid = 1;
            s[i] = clip32(mag_neg[i-6] ? -s[i] : s[i]);
        end
        r.out_accel_x = 32'(s[0]); r.out_accel_y = 32'(s[1]); r.out_accel_z = 32'(s[2]);
        r.out_gyro_x  = 32'(s[3]); r.out_gyro_y  = 32'(s[4]); r.out_gyro_z  = 32'(s[5]);
        r.out_mag_x   = 32'(s[6]); r.out_mag_y   = 32'(s[7]); r.out_mag_z   = 32'(s[8]);
        r.calibrated = cal_done;
        r.sensor_missing = imu_missing;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = corrected_q.size();

    always @(posedge i_clk) begin
        t_imu_out want;
        if (!i_rst_n) begin
            gyro_en = 1; accel_en = 1;
            gyro_n = 200; accel_n = 200;
            imu_neg = 5; mag_neg = 5;
            foreach (axis_sum[i]) axis_sum[i] = 0;
            for (int i = 0; i < 3; i++) begin
                gyro_bias[i] = 0;
                accel_bias[i] = 0;
            end
            n_summed = 0;
            cal_done = 0;
            imu_missing = 0;
            corrected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GYRO_EN:  gyro_en  = i_cfg_wdata[0];
                    CFG_ACCEL_EN: accel_en = i_cfg_wdata[0];
                    CFG_GYRO_N:   gyro_n   = i_cfg_wdata;
                    CFG_ACCEL_N:  accel_n  = i_cfg_wdata;
                    CFG_IMU_NEG:  imu_neg  = i_cfg_wdata[2:0];
                    CFG_MAG_NEG:  mag_neg  = i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) corrected_q = {corrected_q, correct_sample(i_in)};
            if (i_out_valid && !i_out_stall) begin
                if (corrected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors++;
                end else begin
                    want = corrected_q.pop_front();
                    check_field("out_accel_x", longint'(want.out_accel_x),
                                longint'(i_out.out_accel_x));
                    check_field("out_accel_y", longint'(want.out_accel_y),
                                longint'(i_out.out_accel_y));
                    check_field("out_accel_z", longint'(want.out_accel_z),
                                longint'(i_out.out_accel_z));
                    check_field("out_gyro_x", longint'(want.out_gyro_x),
                                longint'(i_out.out_gyro_x));
                    check_field("out_gyro_y", longint'(want.out_gyro_y),
                                longint'(i_out.out_gyro_y));
                    check_field("out_gyro_z", longint'(want.out_gyro_z),
                                longint'(i_out.out_gyro_z));
                    check_field("out_mag_x", longint'(want.out_mag_x),
                                longint'(i_out.out_mag_x));
                    check_field("out_mag_y", longint'(want.out_mag_y),
                                longint'(i_out.out_mag_y));
                    check_field("out_mag_z", longint'(want.out_mag_z),
                                longint'(i_out.out_mag_z));
                    check_field("mag_valid", longint'(want.mag_valid),
                                longint'(i_out.mag_valid));
                    check_field("calibrated", longint'(want.calibrated),
                                longint'(i_out.calibrated));
                    check_field("sensor_missing", longint'(want.sensor_missing),
                                longint'(i_out.sensor_missing));
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives IMU samples and register writes into the bias calibration block
// through a pass-through phase with both enables clear, one calibration run and
// seven corrected-sample phases, with random bursts, gaps and output stalls; the
// checker does the comparing.
module tb;
    import imubc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int G_Q16 = 642908;   // 9.81 m/s^2

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_in_valid = 0;
    logic              o_in_stall;
    t_imu_in           i_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 0;
    t_imu_out          o_out;
    logic              i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_GYRO_EN;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;

    int errors, pending;
    int n_sent = 0;
    int burst_left = 0;
    int cycles = 0;

    always #6 i_clk = ~i_clk;

    imu_bias_calibration dut (.*);

    imubc_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_in,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out(o_out),
        .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: duty-cycle stalls, one long hold-off once the run is going
    initial begin
        int duty, left, hold;
        bit held;
        duty = 0; left = 0; hold = 0; held = 0;
        forever begin
            @(posedge i_clk);
            if (!held && n_sent >= 120) begin
                held = 1;
                hold = 600;
            end
            if (left == 0) begin
                duty = $urandom_range(0, 3);
                left = $urandom_range(16, 96);
            end
            left--;
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) < duty);
            end
        end
    end

    task automatic send(t_imu_in x);
        int gap;
        i_in_valid <= 1;
        i_in <= x;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // write enable drops for a cycle between writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= CNT_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] noisy(int centre, int spread);
        return centre + $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // still sensor with noise; occasionally a wild value, sometimes no magnetometer
    function automatic t_imu_in imu_sample(bit zero_motion);
        t_imu_in x;
        x.accel_x = noisy(3000, 2000);
        x.accel_y = noisy(-1500, 2000);
        x.accel_z = noisy(($urandom_range(0, 1) ? G_Q16 : -G_Q16), 5000);
        x.gyro_x  = noisy(400, 300);
        x.gyro_y  = noisy(-250, 300);
        x.gyro_z  = noisy(100, 300);
        x.mag_x   = $urandom;
        x.mag_y   = $urandom;
        x.mag_z   = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            x.accel_x = $urandom; x.accel_y = $urandom; x.accel_z = $urandom;
            x.gyro_x  = $urandom; x.gyro_y  = $urandom; x.gyro_z  = $urandom;
        end
        if ($urandom_range(0, 7) == 0) x.mag_x = $urandom_range(0, 1);
        if ($urandom_range(0, 5) == 0) {x.mag_x, x.mag_y, x.mag_z} = '0;
        if (zero_motion) {x.accel_x, x.accel_y, x.accel_z,
                          x.gyro_x, x.gyro_y, x.gyro_z} = '0;
        return x;
    endfunction

    initial begin
        logic [31:0] pat [6];
        t_imu_in x;
        int scen, n_cal;
        pat = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0001};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // both enables clear: nothing is summed, extremes go straight through
        write_reg(CFG_GYRO_EN, 0);
        write_reg(CFG_ACCEL_EN, 0);
        write_reg(CFG_IMU_NEG, 7);
        write_reg(CFG_MAG_NEG, 7);
        for (int k = 0; k < 16; k++) begin
            if (k == 8) begin
                drain();
                write_reg(CFG_IMU_NEG, 0);
                write_reg(CFG_MAG_NEG, 0);
            end
            x = {pat[k%6], pat[(k+1)%6], pat[(k+2)%6], pat[(k+3)%6], pat[(k+4)%6],
                 pat[(k+5)%6], pat[(k+2)%6], pat[(k+3)%6], pat[(k+4)%6]};
            if (k % 4 == 3) {x.mag_x, x.mag_y, x.mag_z} = '0;
            send(x);
        end
        drain();

        // one calibration per reset: the seed picks which kind
        scen = $urandom_range(0, 9);
        write_reg(CFG_IMU_NEG, $urandom_range(0, 7));
        write_reg(CFG_MAG_NEG, $urandom_range(0, 7));
        write_reg(CFG_GYRO_N, (scen == 1) ? 0 : $urandom_range(40, 80));
        write_reg(CFG_ACCEL_N, (scen == 1) ? 0 : $urandom_range(40, 80));
        write_reg(CFG_GYRO_EN, scen != 3);
        write_reg(CFG_ACCEL_EN, scen != 2);
        n_cal = (scen == 1) ? 4 : 90;
        for (int k = 0; k < n_cal; k++) begin
            // lowered target: finishes at the next sample
            if (k == 30 && scen >= 4) begin
                drain();
                write_reg(CFG_GYRO_N, $urandom_range(0, 29));
                write_reg(CFG_ACCEL_N, $urandom_range(0, 29));
            end
            send(imu_sample(scen == 0));
        end
        drain();

        // corrected-sample phases; only the sign registers matter now
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_IMU_NEG, (p == 0) ? 0 : (p == 1) ? 7 : $urandom_range(0, 7));
            write_reg(CFG_MAG_NEG, (p == 0) ? 7 : (p == 1) ? 0 : $urandom_range(0, 7));
            write_reg(CFG_GYRO_N, (p % 2) ? 4095 : 0);
            write_reg(CFG_ACCEL_N, (p % 2) ? 0 : 4095);
            write_reg(CFG_GYRO_EN, p % 2);
            write_reg(CFG_ACCEL_EN, (p + 1) % 2);
            for (int k = 0; k < 200; k++) send(imu_sample(0));
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/imubc_pkg.sv
rtl/imubc_div.sv
rtl/imubc_sqrt.sv
rtl/imu_bias_calibration.sv
tb/imubc_checker.sv
tb/tb.sv
